// ===== rtl/gfpr_pkg.sv =====
// Package for the GF(256) polynomial remainder block: widths, register
// indexes, the run tag type and the GF(256) multiply function.
// No dependencies.
`default_nettype none
package gfpr_pkg;

  localparam int unsigned MAX_DEGREE_DEF = 32;  // default window length
  localparam int unsigned DIVISOR_COEFS  = 32;  // g[1]..g[32] held in config
  localparam int unsigned QUEUE_DEPTH    = 2;   // pending remainders, front to back

  localparam int unsigned COEF_W     = 8;
  localparam int unsigned DEG_W      = 6;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIVISOR_W  = DIVISOR_COEFS * COEF_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] RegDegree = 3'd0;
  localparam logic [CFG_IDX_W-1:0] RegWord0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] RegWord1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] RegWord2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] RegWord3  = 3'd4;

  // low byte of the field polynomial x^8 + x^4 + x^3 + x + 1
  localparam logic [COEF_W-1:0] GfPolyLow = 8'h1B;

  // per-run information handed from front to back with the remainder
  typedef struct packed {
    logic [DEG_W-1:0] degree;
    logic             short_run;
  } gfpr_tag_t;

  // shift-and-add GF(256) product, eight narrow steps
  function automatic logic [COEF_W-1:0] gf_mul(input logic [COEF_W-1:0] a,
                                                input logic [COEF_W-1:0] b);
    logic [COEF_W-1:0] acc;
    logic [COEF_W-1:0] x;
    acc = '0;
    x   = a;
    for (int i = 0; i < COEF_W; i++) begin
      if (b[i]) acc = acc ^ x;
      x = {x[COEF_W-2:0], 1'b0} ^ (x[COEF_W-1] ? GfPolyLow : '0);
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gf256_polynomial_remainder_top.sv =====
// Top level of the streaming GF(256) polynomial remainder unit: config
// registers, front end, remainder queue and result sequencer.
// Depends on gfpr_pkg, gfpr_front, gfpr_queue, gfpr_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | sink      | in_valid_i / in_ready_o | coefficient_i, final_item_i
//   out     | source    | out_valid_o/out_ready_i | remainder_value_o, remainder_index_o,
//           |           |                         | final_result_o, short_error_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Cycles: one dividend coefficient is accepted per cycle; the window update is
//   a single level of GF multiply-XOR lanes. A final coefficient hands the
//   remainder to a QUEUE_DEPTH-entry queue; the back end sends D results at one
//   per cycle when out_ready_i allows; the next remainder loads as the last leaves.
// Stalls: in_ready_o drops only while the queue holds QUEUE_DEPTH remainders.
// Reset: window and counts clear at once; no clearing pass. cfg_ready_o is
//   always high.
`default_nettype none
module gf256_polynomial_remainder_top #(
  parameter int unsigned MAX_DEGREE  = gfpr_pkg::MAX_DEGREE_DEF,
  parameter int unsigned QUEUE_DEPTH = gfpr_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // coefficient requests
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [gfpr_pkg::COEF_W-1:0]      coefficient_i,
  input  wire logic                             final_item_i,
  // remainder requests
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [gfpr_pkg::COEF_W-1:0]           remainder_value_o,
  output logic [gfpr_pkg::IDX_W-1:0]            remainder_index_o,
  output logic                                  final_result_o,
  output logic                                  short_error_o,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [gfpr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [gfpr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import gfpr_pkg::*;

  localparam int unsigned WinW   = MAX_DEGREE * COEF_W;
  localparam int unsigned EntryW = WinW + $bits(gfpr_tag_t);
  localparam logic [DEG_W-1:0] MaxDeg = DEG_W'(MAX_DEGREE);

  // ---------------- configuration registers ----------------
  logic [DEG_W-1:0]      degree_q;
  logic [CFG_DATA_W-1:0] word0_q, word1_q, word2_q, word3_q;
  logic [DEG_W-1:0]      eff_degree;
  logic [DIVISOR_W-1:0]  divisor;
  logic                  cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEG_W'(1);
      word0_q  <= '0;
      word1_q  <= '0;
      word2_q  <= '0;
      word3_q  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        RegDegree: degree_q <= cfg_data_i[DEG_W-1:0];
        RegWord0:  word0_q  <= cfg_data_i;
        RegWord1:  word1_q  <= cfg_data_i;
        RegWord2:  word2_q  <= cfg_data_i;
        RegWord3:  word3_q  <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // zero degree acts as one, oversize degree clamps to the window length
  assign eff_degree = (degree_q == '0)    ? DEG_W'(1) :
                      (degree_q > MaxDeg) ? MaxDeg : degree_q;
  // g[1] sits in the low byte of word 0
  assign divisor = {word3_q, word2_q, word1_q, word0_q};

  // ---------------- front end ----------------
  logic             push;
  logic [WinW-1:0]  push_win;
  gfpr_tag_t        push_tag;
  logic             queue_full;

  gfpr_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coefficient_i (coefficient_i),
    .final_item_i  (final_item_i),
    .degree_i      (eff_degree),
    .divisor_i     (divisor),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_win_o    (push_win),
    .push_tag_o    (push_tag)
  );

  // ---------------- remainder queue ----------------
  logic              pop;
  logic              queue_valid;
  logic [EntryW-1:0] queue_head;
  gfpr_tag_t         head_tag;
  logic [WinW-1:0]   head_win;

  gfpr_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_tag, push_win}),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .head_o      (queue_head)
  );

  assign head_win = queue_head[WinW-1:0];
  assign head_tag = queue_head[EntryW-1:WinW];

  // ---------------- result sequencer ----------------
  gfpr_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .queue_valid_i     (queue_valid),
    .queue_win_i       (head_win),
    .queue_tag_i       (head_tag),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .remainder_value_o (remainder_value_o),
    .remainder_index_o (remainder_index_o),
    .final_result_o    (final_result_o),
    .short_error_o     (short_error_o)
  );

endmodule
`default_nettype wire

// ===== rtl/gfpr_queue.sv =====
// Short FIFO between the division front end and the result sequencer.
// Depends on nothing but its parameters.
`default_nettype none
module gfpr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + CntW'(1);
    if (pop_i && !push_i) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/gfpr_front.sv =====
// Front end: accepts dividend coefficients and updates the remainder window,
// one GF multiply-XOR level per coefficient. Uses gfpr_pkg.
`default_nettype none
module gfpr_front #(
  parameter int unsigned MAX_DEGREE = gfpr_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [gfpr_pkg::COEF_W-1:0]       coefficient_i,
  input  wire logic                              final_item_i,
  input  wire logic [gfpr_pkg::DEG_W-1:0]        degree_i,
  input  wire logic [gfpr_pkg::DIVISOR_W-1:0]    divisor_i,
  input  wire logic                              queue_full_i,
  output logic                                   push_o,
  output logic [MAX_DEGREE*gfpr_pkg::COEF_W-1:0] push_win_o,
  output gfpr_pkg::gfpr_tag_t                    push_tag_o
);
  import gfpr_pkg::*;

  logic [COEF_W-1:0] win_q [MAX_DEGREE];
  logic [COEF_W-1:0] win_d [MAX_DEGREE];
  logic [DEG_W-1:0]  cnt_q, cnt_d;
  logic [DEG_W-1:0]  cnt_inc;
  logic              accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // oldest entry is the quotient coefficient for this step
  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_lane
    logic [COEF_W-1:0] older;
    logic [COEF_W-1:0] g_coef;
    if (k + 1 < MAX_DEGREE) begin : g_mid
      assign older = (DEG_W'(k + 1) < degree_i) ? win_q[k+1] : coefficient_i;
    end else begin : g_end
      assign older = coefficient_i;
    end
    if (k < DIVISOR_COEFS) begin : g_coef_on
      assign g_coef = divisor_i[k*COEF_W +: COEF_W];
    end else begin : g_coef_off
      assign g_coef = '0;
    end
    assign win_d[k] = (DEG_W'(k) < degree_i) ? (older ^ gf_mul(g_coef, win_q[0])) : '0;
    assign push_win_o[k*COEF_W +: COEF_W] = win_d[k];
  end

  assign cnt_inc = cnt_q + DEG_W'(1);
  assign cnt_d   = (cnt_inc > degree_i) ? degree_i : cnt_inc;

  assign push_o               = accept && final_item_i;
  assign push_tag_o.degree    = degree_i;
  assign push_tag_o.short_run = (cnt_d < degree_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int k = 0; k < MAX_DEGREE; k++) win_q[k] <= '0;
    end else if (accept) begin
      if (final_item_i) begin
        cnt_q <= '0;
        for (int k = 0; k < MAX_DEGREE; k++) win_q[k] <= '0;
      end else begin
        cnt_q <= cnt_d;
        for (int k = 0; k < MAX_DEGREE; k++) win_q[k] <= win_d[k];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gfpr_back.sv =====
// Back end: takes a finished remainder from the queue and sends its coefficients out
// one per cycle when out_ready_i allows, through a registered output. Uses gfpr_pkg.
`default_nettype none
module gfpr_back #(
  parameter int unsigned MAX_DEGREE = gfpr_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   queue_valid_i,
  input  wire logic [MAX_DEGREE*gfpr_pkg::COEF_W-1:0] queue_win_i,
  input  wire gfpr_pkg::gfpr_tag_t                    queue_tag_i,
  output logic                                        pop_o,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [gfpr_pkg::COEF_W-1:0]                 remainder_value_o,
  output logic [gfpr_pkg::IDX_W-1:0]                  remainder_index_o,
  output logic                                        final_result_o,
  output logic                                        short_error_o
);
  import gfpr_pkg::*;

  logic [COEF_W-1:0] sh_q [MAX_DEGREE];
  logic [COEF_W-1:0] sh_next [MAX_DEGREE];
  logic [DEG_W-1:0]  idx_q;
  logic [DEG_W-1:0]  deg_q;
  logic              short_q;
  logic              busy_q;
  logic              out_valid_q;
  logic              emit;
  logic              last;

  // next remainder loads while the last coefficient of the current one leaves
  assign pop_o = queue_valid_i && (!busy_q || (emit && last));
  assign emit  = busy_q && (!out_valid_q || out_ready_i);
  assign last  = ((idx_q + DEG_W'(1)) == deg_q);

  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_shift
    if (k + 1 < MAX_DEGREE) begin : g_mid
      assign sh_next[k] = sh_q[k+1];
    end else begin : g_end
      assign sh_next[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        idx_q <= idx_q + DEG_W'(1);
        if (last) busy_q <= 1'b0;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      deg_q   <= queue_tag_i.degree;
      short_q <= queue_tag_i.short_run;
      for (int k = 0; k < MAX_DEGREE; k++) sh_q[k] <= queue_win_i[k*COEF_W +: COEF_W];
    end else if (emit) begin
      for (int k = 0; k < MAX_DEGREE; k++) sh_q[k] <= sh_next[k];
    end
    if (emit) begin
      remainder_value_o <= sh_q[0];
      remainder_index_o <= idx_q[IDX_W-1:0];
      final_result_o    <= last;
      short_error_o     <= short_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== dv/tb_gf256_polynomial_remainder_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gf256_polynomial_remainder_top: directed table, then random
// dividends under several divisor settings, checked against an in-bench remainder predictor.
// Depends on gfpr_pkg and the RTL of gf256_polynomial_remainder_top.
module tb_gf256_polynomial_remainder_top;
  import gfpr_pkg::*;

  localparam int MAX_DEG       = 32;
  localparam int RANDOM_ITEMS  = 420;
  localparam int IDLE_PCT      = 15;
  localparam int LONG_HOLD     = 400;       // receiver hold-off, in cycles
  localparam int SETTLE_CYCLES = 4;         // block is single-level
  localparam int TAIL_CYCLES   = 40;
  localparam logic [COEF_W-1:0] FIELD_TAPS = 8'h1B;  // x^8 folds back as x^4+x^3+x+1

  // one remainder coefficient as it leaves the block
  typedef struct packed {
    logic [COEF_W-1:0] value;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic              short_flag;
  } rem_coef_t;

  typedef enum logic {RowReg, RowCoef} row_kind_e;

  // directed table row; typed rows carry the leading remainder value and short flag
  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] data;
    logic [COEF_W-1:0]    coef;
    logic                 last;
    bit                   typed;
    logic [COEF_W-1:0]    lead;
    bit                   lead_short;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COEF_W-1:0]     coefficient = '0;
  logic                  final_item = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COEF_W-1:0]     remainder_value;
  logic [IDX_W-1:0]      remainder_index;
  logic                  final_result;
  logic                  short_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state: divisor settings, partial-remainder window, dividend length so far
  logic [DEG_W-1:0]      deg_reg = 6'd1;
  logic [CFG_DATA_W-1:0] div_word [4] = '{default: '0};
  logic [COEF_W-1:0]     partial [MAX_DEG] = '{default: '0};
  int                    coef_count = 0;
  rem_coef_t             step_out [MAX_DEG];

  rem_coef_t remainder_fifo [$];      // predicted coefficients still to arrive
  int        mismatches = 0;
  int        items_sent = 0;
  bit        steady = 1'b0;           // no idling on either side while set
  bit        hold_req = 1'b0;         // ask the receiver for its long hold-off

  gf256_polynomial_remainder_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .coefficient_i     (coefficient),
    .final_item_i      (final_item),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .remainder_value_o (remainder_value),
    .remainder_index_o (remainder_index),
    .final_result_o    (final_result),
    .short_error_o     (short_error),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("gf256_polynomial_remainder_top: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] %s", $realtime, what);
  endtask

  // GF(256) product, Horner form: walk the multiplier from its top bit down.
  function automatic logic [COEF_W-1:0] gf_times(input logic [COEF_W-1:0] a,
                                                 input logic [COEF_W-1:0] b);
    logic [COEF_W-1:0] acc;
    acc = '0;
    for (int i = COEF_W - 1; i >= 0; i--) begin
      acc = {acc[COEF_W-2:0], 1'b0} ^ (acc[COEF_W-1] ? FIELD_TAPS : '0);
      if (b[i]) acc = acc ^ a;
    end
    return acc;
  endfunction

  // degree 0 behaves as 1, anything past the window length as the full window
  function automatic int eff_degree();
    int d;
    d = int'(deg_reg);
    if (d < 1) d = 1;
    if (d > MAX_DEG) d = MAX_DEG;
    return d;
  endfunction

  // divisor coefficient g[k], k = 1..32; the monic leading term is implied
  function automatic logic [COEF_W-1:0] divisor_coef(input int k);
    if (k < 1 || k > MAX_DEG) return '0;
    return div_word[(k - 1) / 8][((k - 1) % 8) * 8 +: 8];
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      RegDegree: deg_reg = data[DEG_W-1:0];
      RegWord0:  div_word[0] = data;
      RegWord1:  div_word[1] = data;
      RegWord2:  div_word[2] = data;
      RegWord3:  div_word[3] = data;
      default: ;
    endcase
  endfunction

  // One long-division step. Returns how many remainder coefficients it releases
  // (zero unless this is the dividend's last coefficient) and leaves them in step_out.
  function automatic int divide_step(input logic [COEF_W-1:0] c, input logic last);
    int                d;
    logic [COEF_W-1:0] q;
    logic [COEF_W-1:0] v;
    bit                short_run;
    d = eff_degree();
    q = partial[0];              // quotient coefficient, dropped
    for (int k = 0; k < MAX_DEG; k++) begin
      if (k >= d) begin
        partial[k] = '0;
      end else begin
        v = (k + 1 < d) ? partial[k + 1] : c;
        partial[k] = v ^ gf_times(divisor_coef(k + 1), q);
      end
    end
    coef_count = (coef_count + 1 > d) ? d : coef_count + 1;
    if (!last) return 0;
    short_run = coef_count < d;
    for (int k = 0; k < d; k++) begin
      step_out[k] = '{value: partial[k], idx: IDX_W'(k), last: (k + 1 == d),
                      short_flag: short_run};
    end
    partial = '{default: '0};
    coef_count = 0;
    return d;
  endfunction

  // Offer one coefficient; predict at the accepting edge. Valid is left high.
  task automatic send_coef(input logic [COEF_W-1:0] c, input logic last, input bit typed,
                           input logic [COEF_W-1:0] lead, input bit lead_short);
    int n;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    coefficient <= c;
    final_item  <= last;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    n = divide_step(c, last);
    for (int i = 0; i < n; i++) begin
      if (typed) begin
        if (i == 0) step_out[i].value = lead;
        step_out[i].short_flag = lead_short;
      end
      remainder_fifo.push_back(step_out[i]);
    end
  endtask

  // Register write; cfg_valid is left high so back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic wait_drain();
    while (remainder_fifo.size() != 0) @(posedge clk_i);
  endtask

  // stop offering, let every predicted coefficient arrive, then let the block settle
  task automatic quiesce();
    in_valid <= 1'b0;
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    return '{kind: RowReg, reg_idx: idx, data: data, coef: '0, last: 1'b0,
             typed: 1'b0, lead: '0, lead_short: 1'b0};
  endfunction

  function automatic stim_row_t coef_row(input logic [COEF_W-1:0] c, input logic last);
    return '{kind: RowCoef, reg_idx: '0, data: '0, coef: c, last: last,
             typed: 1'b0, lead: '0, lead_short: 1'b0};
  endfunction

  // final coefficient with the leading remainder value written in by hand
  function automatic stim_row_t lead_row(input logic [COEF_W-1:0] c,
                                         input logic [COEF_W-1:0] lead, input bit shrt);
    return '{kind: RowCoef, reg_idx: '0, data: '0, coef: c, last: 1'b1,
             typed: 1'b1, lead: lead, lead_short: shrt};
  endfunction

  function automatic int pick_degree(input int phase);
    int r;
    if (phase == 0) return 2;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32;
      1:       return $urandom_range(33, 63);
      2:       return 0;
      3:       return 1;
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return COEF_W'($urandom_range(0, 255));
  endfunction

  // mostly well-formed dividends (at least D long), some short ones
  function automatic int pick_length(input int d, input int phase);
    int r;
    if (phase == 0) return $urandom_range(2, 4);
    r = $urandom_range(0, 7);
    if (r == 0) return (d > 1) ? $urandom_range(1, d - 1) : 1;
    if (r == 1) return d;
    return d + $urandom_range(1, 6);
  endfunction

  // Receiver: random back-pressure, one long hold-off on request, and none while steady.
  initial begin : remainder_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done && hold_left == 0) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare every accepted remainder coefficient with the oldest prediction.
  initial begin : remainder_checker
    rem_coef_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && out_ready) begin
        if (remainder_fifo.size() == 0) begin
          flag_mismatch($sformatf("unexpected remainder coefficient %02h at index %0d",
                                  remainder_value, remainder_index));
        end else begin
          want = remainder_fifo.pop_front();
          if (remainder_value !== want.value)
            flag_mismatch($sformatf("remainder_value: got %02h want %02h at index %0d",
                                    remainder_value, want.value, want.idx));
          if (remainder_index !== want.idx)
            flag_mismatch($sformatf("remainder_index: got %0d want %0d",
                                    remainder_index, want.idx));
          if (final_result !== want.last)
            flag_mismatch($sformatf("final_result: got %b want %b at index %0d",
                                    final_result, want.last, want.idx));
          if (short_error !== want.short_flag)
            flag_mismatch($sformatf("short_error: got %b want %b at index %0d",
                                    short_error, want.short_flag, want.idx));
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin : stimulus
    stim_row_t directed_rows [$];
    bit        prev_reg;
    int        phase;
    int        d;
    int        n_div;
    int        len;
    int        start_items;

    directed_rows = '{
      // after reset: D = 1 and a zero divisor, so the remainder is the last coefficient
      coef_row(8'h3C, 1'b0),
      lead_row(8'hFF, 8'hFF, 1'b0),
      lead_row(8'h00, 8'h00, 1'b0),
      // short dividend: padded with leading zeros, flagged on every coefficient
      reg_row(RegDegree, 64'd4),
      coef_row(8'h12, 1'b0),
      lead_row(8'h34, 8'h00, 1'b1),
      // degree field above the window clamps to 32; divisor all ones in every word
      reg_row(RegDegree, 64'd63),
      reg_row(RegWord0, '1),
      reg_row(RegWord1, '1),
      reg_row(RegWord2, '1),
      reg_row(RegWord3, '1),
      coef_row(8'hFF, 1'b0),
      coef_row(8'h01, 1'b0),
      lead_row(8'h80, 8'h00, 1'b1),
      // degree 0 acts as 1; with g1 = 1 the remainder is A5 ^ 5A
      reg_row(RegDegree, 64'd0),
      reg_row(RegWord0, 64'd1),
      coef_row(8'hA5, 1'b0),
      lead_row(8'h5A, 8'hFF, 1'b0),
      // small full division, predictor only
      reg_row(RegDegree, 64'd2),
      reg_row(RegWord0, 64'h0302),
      coef_row(8'h80, 1'b0),
      coef_row(8'h01, 1'b0),
      coef_row(8'hFF, 1'b0),
      coef_row(8'h7F, 1'b1),
      // degree raised partway through a dividend
      reg_row(RegDegree, 64'd3),
      reg_row(RegWord0, 64'h0000_0000_004D_1FE7),
      coef_row(8'h11, 1'b0),
      coef_row(8'h22, 1'b0),
      reg_row(RegDegree, 64'd5),
      coef_row(8'h33, 1'b0),
      coef_row(8'h44, 1'b1)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev_reg = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowReg) begin
        if (!prev_reg) quiesce();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].data);
        prev_reg = 1'b1;
      end else begin
        if (prev_reg) cfg_valid <= 1'b0;
        send_coef(directed_rows[i].coef, directed_rows[i].last, directed_rows[i].typed,
                  directed_rows[i].lead, directed_rows[i].lead_short);
        prev_reg = 1'b0;
      end
    end

    // Random phases: new divisor settings each time, then a batch of dividends.
    // Phase 0 runs against the receiver's long hold-off so the queue backs up;
    // phase 2 is a stretch without idling on either side.
    start_items = items_sent;
    phase = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      quiesce();
      write_reg(RegDegree, 64'(pick_degree(phase)));
      write_reg(RegWord0, pick_word());
      write_reg(RegWord1, pick_word());
      write_reg(RegWord2, pick_word());
      write_reg(RegWord3, pick_word());
      cfg_valid <= 1'b0;
      d = eff_degree();
      steady   = (phase == 2);
      hold_req = (phase == 0);
      if (phase == 0) n_div = 10;
      else n_div = (d >= 16) ? 2 : $urandom_range(3, 8);
      for (int j = 0; j < n_div; j++) begin
        // now and then the sender waits for every pending coefficient to come back
        if (phase != 0 && !steady && remainder_fifo.size() != 0 &&
            $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          wait_drain();
        end
        len = pick_length(d, phase);
        for (int i = 0; i < len; i++) send_coef(pick_coef(), i == len - 1, 1'b0, '0, 1'b0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    steady = 1'b0;
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (remainder_fifo.size() != 0)
      flag_mismatch($sformatf("%0d remainder coefficients never arrived", remainder_fifo.size()));
    if (mismatches == 0) begin
      $display("gf256_polynomial_remainder_top: match");
    end else begin
      $display("gf256_polynomial_remainder_top: mismatch");
    end
    $finish;
  end

endmodule
